// File: src/cbpe_pkg.sv
// Package for the cubic Bezier point evaluator: widths, payload structs,
// pipeline control struct and the weight bundle. No dependencies.
package cbpe_pkg;

  // Sample index width and coordinate width
  localparam int STEP_BITS   = 9;
  localparam int COORD_BITS  = 16;

  // Derived widths
  localparam int A_W         = STEP_BITS + 1;          // a = 2^STEP_BITS - i
  localparam int SQ_A_W      = 2 * A_W;
  localparam int SQ_B_W      = 2 * STEP_BITS;
  localparam int SCALE_SHIFT = 3 * STEP_BITS;          // weight denominator
  localparam int WGT_W       = SCALE_SHIFT + 1;        // a weight can equal 2^SCALE_SHIFT
  localparam int PROD_W      = WGT_W + COORD_BITS;
  localparam int ACC_W       = SCALE_SHIFT + COORD_BITS;
  localparam int NUM_CP      = 4;                      // control points
  localparam int NUM_STG     = 5;                      // pipeline depth

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        ucoord_t;
  typedef logic [STEP_BITS-1:0]         step_t;

  typedef struct packed {
    coord_t p0_x;
    coord_t p0_y;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p3_x;
    coord_t p3_y;
    step_t  sample_index;
  } cbpe_in_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
  } cbpe_out_t;

  // Bernstein weights, scaled by 2^SCALE_SHIFT
  typedef struct packed {
    logic [NUM_CP-1:0][WGT_W-1:0] w;
  } wgt_t;

  // Per-stage load enables shared by the weight unit and the lanes
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic s4_en;
  } cbpe_ctl_t;

endpackage

// File: src/cubic_bezier_point_eval.sv
// Top level of the cubic Bezier point evaluator: pipeline control, the
// weight unit, two coordinate lanes and the merging output register.
// Depends on cbpe_pkg, cbpe_weights and cbpe_lane.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries four control points and a
//   sample index i (t = i/512). Output channel out_valid/out_ready/out_data
//   returns the curve point, rounded half up, one per input transaction, in
//   order.
//   From acceptance to out_valid, two stages build the Bernstein weights,
//   one multiplies, one adds pairs, and the output register takes the final
//   add and rounding for both lanes at once.
//   Throughput is one transaction per cycle when the receiver does not stall;
//   each lane has four multipliers and the weight unit six more, none shared.
//   When the receiver stalls, the result holds in the output register and
//   stages behind it keep filling any empty slots, so input is still taken
//   until all five stages hold data.
//   Synchronous active-low reset empties the pipeline; no result is pending
//   after reset.
module cubic_bezier_point_eval import cbpe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cbpe_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output cbpe_out_t out_data
);

  logic [NUM_STG:1]    vld_r;
  logic [NUM_STG:1]    vld_nxt;
  logic [NUM_STG:1]    rdy;
  logic [NUM_STG:1]    load;
  logic [NUM_STG:0]    vin;
  cbpe_ctl_t           ctl;
  wgt_t                wgt;
  coord_t [NUM_CP-1:0] cx;
  coord_t [NUM_CP-1:0] cy;
  coord_t              lane_x;
  coord_t              lane_y;
  cbpe_out_t           out_data_r;

  // Stage readiness: a stage takes data when empty or when it drains ahead
  always_comb begin
    rdy[NUM_STG] = !vld_r[NUM_STG] || out_ready;
    for (int k = NUM_STG - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vin = {vld_r, in_valid};
    for (int k = 1; k <= NUM_STG; k++) begin
      load[k]    = rdy[k] && vin[k-1];
      vld_nxt[k] = rdy[k] ? vin[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = rdy[1];
  assign ctl.s1_en = load[1];
  assign ctl.s2_en = load[2];
  assign ctl.s3_en = load[3];
  assign ctl.s4_en = load[4];

  assign cx = {in_data.p3_x, in_data.p2_x, in_data.p1_x, in_data.p0_x};
  assign cy = {in_data.p3_y, in_data.p2_y, in_data.p1_y, in_data.p0_y};

  cbpe_weights u_weights (
    .clk          (clk),
    .ctl          (ctl),
    .sample_index (in_data.sample_index),
    .wgt          (wgt)
  );

  cbpe_lane u_lane_x (
    .clk   (clk),
    .ctl   (ctl),
    .coord (cx),
    .wgt   (wgt),
    .point (lane_x)
  );

  cbpe_lane u_lane_y (
    .clk   (clk),
    .ctl   (ctl),
    .coord (cy),
    .wgt   (wgt),
    .point (lane_y)
  );

  // Merge both lanes into the output register
  always_ff @(posedge clk) begin
    if (load[NUM_STG]) begin
      out_data_r.point_x <= lane_x;
      out_data_r.point_y <= lane_y;
    end
  end

  assign out_valid = vld_r[NUM_STG];
  assign out_data  = out_data_r;

endmodule

// File: src/cbpe_weights.sv
// Bernstein weight generator: two pipeline stages from sample index to weights.
// Depends on cbpe_pkg.
module cbpe_weights import cbpe_pkg::*; (
  input  logic      clk,
  input  cbpe_ctl_t ctl,
  input  step_t     sample_index,
  output wgt_t      wgt
);

  logic [A_W-1:0]    a_nxt;
  logic [A_W-1:0]    a_r;
  step_t             b_r;
  logic [SQ_A_W-1:0] a2_r;
  logic [SQ_B_W-1:0] b2_r;
  logic [WGT_W-1:0]  m1;
  logic [WGT_W-1:0]  m2;
  wgt_t              wgt_nxt;
  wgt_t              wgt_r;

  // a = 2^STEP_BITS - i, never zero
  assign a_nxt = (A_W'(1) << STEP_BITS) - A_W'(sample_index);

  // Stage 1: squares of a and b
  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      a_r  <= a_nxt;
      b_r  <= sample_index;
      a2_r <= SQ_A_W'(a_nxt) * SQ_A_W'(a_nxt);
      b2_r <= SQ_B_W'(sample_index) * SQ_B_W'(sample_index);
    end
  end

  // Stage 2: cubes and mixed terms; times three is a shift and add
  always_comb begin
    m1 = WGT_W'(a2_r) * WGT_W'(b_r);
    m2 = WGT_W'(b2_r) * WGT_W'(a_r);
    wgt_nxt.w[0] = WGT_W'(a2_r) * WGT_W'(a_r);
    wgt_nxt.w[1] = m1 + (m1 << 1);
    wgt_nxt.w[2] = m2 + (m2 << 1);
    wgt_nxt.w[3] = WGT_W'(b2_r) * WGT_W'(b_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      wgt_r <= wgt_nxt;
    end
  end

  assign wgt = wgt_r;

endmodule

// File: src/cbpe_lane.sv
// One coordinate lane: bias, weight products, summation and rounding.
// Depends on cbpe_pkg; the weights come from cbpe_weights.
module cbpe_lane import cbpe_pkg::*; (
  input  logic                     clk,
  input  cbpe_ctl_t                ctl,
  input  coord_t [NUM_CP-1:0]      coord,
  input  wgt_t                     wgt,
  output coord_t                   point
);

  ucoord_t [NUM_CP-1:0]    u_s1_r;
  ucoord_t [NUM_CP-1:0]    u_s2_r;
  logic [NUM_CP-1:0][ACC_W-1:0] prod_r;
  logic [ACC_W-1:0]        sum_a_r;
  logic [ACC_W-1:0]        sum_b_r;
  logic [ACC_W-1:0]        total;
  ucoord_t                 rnd;

  // Stage 1: offset each coordinate to unsigned by flipping its sign bit
  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      for (int k = 0; k < NUM_CP; k++) begin
        u_s1_r[k] <= {~coord[k][COORD_BITS-1], coord[k][COORD_BITS-2:0]};
      end
    end
  end

  // Stage 2: hold coordinates while the weights finish
  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      u_s2_r <= u_s1_r;
    end
  end

  // Stage 3: one product per control point
  always_ff @(posedge clk) begin
    if (ctl.s3_en) begin
      for (int k = 0; k < NUM_CP; k++) begin
        prod_r[k] <= ACC_W'(PROD_W'(wgt.w[k]) * PROD_W'(u_s2_r[k]));
      end
    end
  end

  // Stage 4: pairwise sums, rounding half folded into the first
  always_ff @(posedge clk) begin
    if (ctl.s4_en) begin
      sum_a_r <= prod_r[0] + prod_r[1] + (ACC_W'(1) << (SCALE_SHIFT - 1));
      sum_b_r <= prod_r[2] + prod_r[3];
    end
  end

  // Final add, drop the fraction, remove the offset
  always_comb begin
    total = sum_a_r + sum_b_r;
    rnd   = total[ACC_W-1:SCALE_SHIFT];
    point = {~rnd[COORD_BITS-1], rnd[COORD_BITS-2:0]};
  end

endmodule

// File: src/cbpe_checker.sv
// Port-level checker for the cubic Bezier point evaluator, bound to the top.
// Depends on cbpe_pkg and cubic_bezier_point_eval.
module cbpe_checker import cbpe_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input cbpe_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input cbpe_out_t out_data
);

  logic [2:0] cnt_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track transactions in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // No result without an accepted transaction in flight
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 3'd0)
    else $error("result without pending transaction");

  // Occupancy never exceeds the pipeline depth
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(NUM_STG))
    else $error("too many transactions in flight");

  // A ready receiver never backs up the input
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while receiver ready");

  // Pipeline is empty on the first cycle out of reset
  a_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind cubic_bezier_point_eval cbpe_checker u_cbpe_checker (.*);

// File: bench/tb_cubic_bezier_point_eval.sv
// Self-checking testbench for cubic_bezier_point_eval: directed and random
// control points and sample indexes, each result checked against a local model.
// Depends on cbpe_pkg and the cubic_bezier_point_eval RTL.
module tb_cubic_bezier_point_eval;
  import cbpe_pkg::*;

  localparam int TOTAL_ITEMS   = 2000;
  localparam int HOLD_OFF_AT   = 400;   // items offered before the long receiver hold-off
  localparam int HOLD_OFF_LEN  = 100;
  localparam int DRAIN_AT      = 1200;  // sender pauses here until every result is back
  localparam int IDLE_LIMIT    = 2000;
  localparam int TAIL_CYCLES   = 3 * NUM_STG;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  cbpe_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  cbpe_out_t out_data;

  cbpe_in_t  pending_items[$];
  cbpe_out_t expected_points[$];

  logic      in_taken = 1'b0;
  int        items_sent = 0;
  int        points_seen = 0;
  int        gap_left = 0;
  int        stall_left = 0;
  bit        hold_off_done = 1'b0;
  int        idle_cycles = 0;
  bit        timed_out = 1'b0;
  int        mismatches = 0;

  cubic_bezier_point_eval dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // Blend four control coordinates with the Bernstein weights, offset to unsigned,
  // and round half up by adding half the scale before the shift.
  function automatic coord_t blend_coord(input coord_t c0, c1, c2, c3,
                                         input logic [63:0] w0, w1, w2, w3);
    logic [63:0] bias;
    logic [63:0] acc;
    logic [63:0] scaled;
    bias = 64'd1 << (COORD_BITS - 1);
    acc = w0 * (64'(ucoord_t'(c0)) ^ bias) + w1 * (64'(ucoord_t'(c1)) ^ bias)
        + w2 * (64'(ucoord_t'(c2)) ^ bias) + w3 * (64'(ucoord_t'(c3)) ^ bias);
    acc = acc + (64'd1 << (SCALE_SHIFT - 1));
    scaled = (acc >> SCALE_SHIFT) ^ bias;
    return coord_t'(scaled[COORD_BITS-1:0]);
  endfunction

  // Curve point at t = i / 2^STEP_BITS
  function automatic cbpe_out_t bezier_point(input cbpe_in_t item);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] w0, w1, w2, w3;
    cbpe_out_t   pt;
    b = 64'(item.sample_index);
    a = (64'd1 << STEP_BITS) - b;
    w0 = a * a * a;
    w1 = 64'd3 * a * a * b;
    w2 = 64'd3 * a * b * b;
    w3 = b * b * b;
    pt.point_x = blend_coord(item.p0_x, item.p1_x, item.p2_x, item.p3_x, w0, w1, w2, w3);
    pt.point_y = blend_coord(item.p0_y, item.p1_y, item.p2_y, item.p3_y, w0, w1, w2, w3);
    return pt;
  endfunction

  function automatic cbpe_in_t make_item(input int x0, y0, x1, y1, x2, y2, x3, y3, idx);
    cbpe_in_t item;
    item.p0_x = coord_t'(x0);
    item.p0_y = coord_t'(y0);
    item.p1_x = coord_t'(x1);
    item.p1_y = coord_t'(y1);
    item.p2_x = coord_t'(x2);
    item.p2_y = coord_t'(y2);
    item.p3_x = coord_t'(x3);
    item.p3_y = coord_t'(y3);
    item.sample_index = step_t'(idx);
    return item;
  endfunction

  // Mostly full-range values, with the extremes and values around zero mixed in
  function automatic coord_t random_coord();
    int pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0: return coord_t'(-32768);
      1: return coord_t'(32767);
      2: return coord_t'(0);
      3: return coord_t'(-1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic int pick_gap(input int phase_count);
    int r;
    // leave some stretches of back-to-back traffic
    if ((phase_count / 128) % 4 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch at point %0d: %s got %0d, want %0d", points_seen, field, got, want);
    mismatches++;
  endtask

  // Driver: present the next transaction once the previous one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (items_sent == DRAIN_AT && expected_points.size() != 0) begin
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        items_sent <= items_sent + 1;
        gap_left <= pick_gap(items_sent);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    int r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!hold_off_done && items_sent >= HOLD_OFF_AT) begin
      out_ready <= 1'b0;
      stall_left <= HOLD_OFF_LEN;
      hold_off_done <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ((points_seen / 160) % 4 == 2) begin
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_ready <= 1'b1;
      end else if (r < 96) begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(20, 50);
      end
    end
  end

  // Monitor: check results, record accepted inputs, watch for a hang
  always @(posedge clk) begin
    cbpe_out_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $display("unexpected point x=%0d y=%0d", out_data.point_x, out_data.point_y);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (out_data.point_x !== want.point_x)
            report_mismatch("point_x", out_data.point_x, want.point_x);
          if (out_data.point_y !== want.point_y)
            report_mismatch("point_y", out_data.point_y, want.point_y);
        end
        points_seen <= points_seen + 1;
      end
      if (in_valid && in_ready) expected_points.push_back(bezier_point(in_data));
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= IDLE_LIMIT) timed_out <= 1'b1;
      end
    end
  end

  initial begin
    cbpe_in_t curve;
    int n_samples;
    int stride;
    int idx;

    // Extremes, endpoints of t and exact halves in rounding
    pending_items.push_back(make_item(-32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768, -32768, 0));
    pending_items.push_back(make_item(32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767, 511));
    pending_items.push_back(make_item(-32768, 32767, 32767, -32768,
                                      -32768, 32767, 32767, -32768, 0));
    pending_items.push_back(make_item(-32768, 32767, 32767, -32768,
                                      -32768, 32767, 32767, -32768, 1));
    pending_items.push_back(make_item(-32768, 32767, 32767, -32768,
                                      -32768, 32767, 32767, -32768, 256));
    pending_items.push_back(make_item(-32768, 32767, 32767, -32768,
                                      -32768, 32767, 32767, -32768, 511));
    pending_items.push_back(make_item(32767, -32768, 32767, -32768,
                                      -32768, 32767, -32768, 32767, 1));
    pending_items.push_back(make_item(32767, -32768, 32767, -32768,
                                      -32768, 32767, -32768, 32767, 510));
    // t stops one step short of the end point
    pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 32767, -32768, 511));
    // exact half at the bottom of the range rounds up
    pending_items.push_back(make_item(-32767, -32767, -32767, -32767,
                                      -32768, -32768, -32768, -32768, 256));
    // exact halves at -0.5 and +0.5 round toward plus infinity
    pending_items.push_back(make_item(0, 0, 0, 0, -1, -1, -1, -1, 256));
    pending_items.push_back(make_item(1, 1, 1, 1, 0, 0, 0, 0, 256));
    pending_items.push_back(make_item(32767, 32767, 32767, 32767,
                                      32766, 32766, 32766, 32766, 256));
    pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0, 137));
    pending_items.push_back(make_item(-1, 1, 1, -1, -1, 1, 1, -1, 85));

    // Random curves tessellated at strided indexes, with lone items as noise
    while (pending_items.size() < TOTAL_ITEMS) begin
      curve.p0_x = random_coord();
      curve.p0_y = random_coord();
      curve.p1_x = random_coord();
      curve.p1_y = random_coord();
      curve.p2_x = random_coord();
      curve.p2_y = random_coord();
      curve.p3_x = random_coord();
      curve.p3_y = random_coord();
      if ($urandom_range(0, 9) == 0) begin
        curve.sample_index = step_t'($urandom);
        pending_items.push_back(curve);
      end else begin
        n_samples = $urandom_range(2, 24);
        stride = $urandom_range(1, 64);
        idx = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 511);
        for (int k = 0; k < n_samples; k++) begin
          curve.sample_index = step_t'(idx);
          pending_items.push_back(curve);
          idx = (idx + stride > 511) ? 511 : idx + stride;
        end
      end
    end

    // Hold reset, then release it between edges
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for all input to be taken and every result to return
    @(posedge clk);
    while (!timed_out &&
           (pending_items.size() != 0 || in_valid || expected_points.size() != 0))
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (!timed_out && mismatches == 0)
      $display("PASS cubic_bezier_point_eval");
    else
      $display("FAIL cubic_bezier_point_eval");
    $finish;
  end

endmodule

// File: sim.f
src/cbpe_pkg.sv
src/cbpe_weights.sv
src/cbpe_lane.sv
src/cubic_bezier_point_eval.sv
src/cbpe_checker.sv
bench/tb_cubic_bezier_point_eval.sv
